@@ rtl/fau_pkg.sv @@
package fau_pkg;

	localparam int NumW  = 16;
	localparam int DenW  = 15;
	localparam int ResNW = 32;
	localparam int ResDW = 31;
	localparam int ShW   = 4;
	localparam int CntW  = 4;
	localparam logic [CntW-1:0] DivSteps = CntW'(DenW);

	typedef enum logic [1:0] {
		CMD_MUL = 2'd0,
		CMD_DIV = 2'd1,
		CMD_ADD = 2'd2,
		CMD_SUB = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_GCD,
		ST_DIV,
		ST_LCM,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_GCD,
		DP_DIV_INIT,
		DP_DIV,
		DP_MUL_DIRECT,
		DP_MUL_SCALE,
		DP_MUL_LCM,
		DP_ZERO,
		DP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_ctrl_t;

	typedef struct packed {
		logic addsub;
		logic den_zero;
		logic gcd_done;
		logic div_done;
	} dp_stat_t;

endpackage

@@ rtl/fau_datapath.sv @@
module fau_datapath
	import fau_pkg::*;
(
	input  logic                    clk,
	input  dp_ctrl_t                ctrl,
	input  logic [1:0]              cmd,
	input  logic signed [NumW-1:0]  a_num,
	input  logic [DenW-1:0]         a_den,
	input  logic signed [NumW-1:0]  b_num,
	input  logic [DenW-1:0]         b_den,
	output dp_stat_t                stat,
	output logic signed [ResNW-1:0] res_num,
	output logic signed [ResDW-1:0] res_den
);

	cmd_t                    cmd_q;
	logic signed [NumW-1:0]  an_q, bn_q;
	logic [DenW-1:0]         ad_q, bd_q;
	logic [DenW-1:0]         x_q, y_q, g_q;
	logic [ShW-1:0]          k_q;
	logic [DenW-1:0]         rem_a_q, rem_b_q, quo_a_q, quo_b_q;
	logic [CntW-1:0]         cnt_q;
	logic signed [ResNW-1:0] prod0_q, prod1_q, num_q, res_num_q;
	logic signed [ResDW-1:0] den_q, res_den_q;

	logic signed [NumW:0]    m0_b, m1_a, m1_b;
	logic signed [32:0]      m0;
	logic signed [33:0]      m1;
	logic [DenW:0]           tr_a, tr_b;
	logic                    ge_a, ge_b;

	always_comb begin
		if (ctrl.op == DP_MUL_SCALE) begin
			m0_b = $signed({2'b00, quo_b_q});
		end else if (cmd_q == CMD_MUL) begin
			m0_b = $signed({bn_q[NumW-1], bn_q});
		end else begin
			m0_b = $signed({2'b00, bd_q});
		end
		if (ctrl.op == DP_MUL_SCALE || ctrl.op == DP_MUL_LCM) begin
			m1_a = $signed({2'b00, quo_a_q});
		end else begin
			m1_a = $signed({2'b00, ad_q});
		end
		if (ctrl.op == DP_MUL_LCM || (ctrl.op != DP_MUL_SCALE && cmd_q == CMD_MUL)) begin
			m1_b = $signed({2'b00, bd_q});
		end else begin
			m1_b = $signed({bn_q[NumW-1], bn_q});
		end
	end

	assign m0 = an_q * m0_b;
	assign m1 = m1_a * m1_b;

	assign tr_a = {rem_a_q, quo_a_q[DenW-1]};
	assign tr_b = {rem_b_q, quo_b_q[DenW-1]};
	assign ge_a = tr_a >= {1'b0, g_q};
	assign ge_b = tr_b >= {1'b0, g_q};

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			DP_LOAD: begin
				cmd_q <= cmd_t'(cmd);
				an_q  <= a_num;
				ad_q  <= a_den;
				bn_q  <= b_num;
				bd_q  <= b_den;
				x_q   <= a_den;
				y_q   <= b_den;
				k_q   <= '0;
			end
			DP_GCD: begin
				if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q >= y_q) begin
					x_q <= (x_q - y_q) >> 1;
				end else begin
					y_q <= (y_q - x_q) >> 1;
				end
			end
			DP_DIV_INIT: begin
				g_q     <= DenW'((x_q | y_q) << k_q);
				rem_a_q <= '0;
				rem_b_q <= '0;
				quo_a_q <= ad_q;
				quo_b_q <= bd_q;
				cnt_q   <= DivSteps;
			end
			DP_DIV: begin
				rem_a_q <= ge_a ? DenW'(tr_a - {1'b0, g_q}) : DenW'(tr_a);
				rem_b_q <= ge_b ? DenW'(tr_b - {1'b0, g_q}) : DenW'(tr_b);
				quo_a_q <= {quo_a_q[DenW-2:0], ge_a};
				quo_b_q <= {quo_b_q[DenW-2:0], ge_b};
				cnt_q   <= cnt_q - 1'b1;
			end
			DP_MUL_DIRECT: begin
				num_q <= m0[ResNW-1:0];
				den_q <= m1[ResDW-1:0];
			end
			DP_MUL_SCALE: begin
				prod0_q <= m0[ResNW-1:0];
				prod1_q <= m1[ResNW-1:0];
			end
			DP_MUL_LCM: begin
				num_q <= (cmd_q == CMD_SUB) ? prod0_q - prod1_q : prod0_q + prod1_q;
				den_q <= m1[ResDW-1:0];
			end
			DP_ZERO: begin
				num_q <= '0;
				den_q <= '0;
			end
			DP_PUBLISH: begin
				res_num_q <= num_q;
				res_den_q <= den_q;
			end
			DP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	assign stat.addsub   = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB);
	assign stat.den_zero = (ad_q == '0) || (bd_q == '0);
	assign stat.gcd_done = (x_q == '0) || (y_q == '0);
	assign stat.div_done = (cnt_q == '0);

	assign res_num = res_num_q;
	assign res_den = res_den_q;

endmodule

@@ rtl/fau_controller.sv @@
module fau_controller
	import fau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_ctrl_t ctrl
);

	state_t state_q, state_nxt;
	logic   out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (stat.addsub && !stat.den_zero) state_nxt = ST_GCD;
				else state_nxt = ST_OUT;
			end
			ST_GCD: begin
				if (stat.gcd_done) state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) state_nxt = ST_LCM;
			end
			ST_LCM: begin
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl.op  = DP_NOP;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) ctrl.op = DP_LOAD;
			end
			ST_DISPATCH: begin
				priority if (!stat.addsub) ctrl.op = DP_MUL_DIRECT;
				else if (stat.den_zero) ctrl.op = DP_ZERO;
				else ctrl.op = DP_NOP;
			end
			ST_GCD: begin
				ctrl.op = stat.gcd_done ? DP_DIV_INIT : DP_GCD;
			end
			ST_DIV: begin
				ctrl.op = stat.div_done ? DP_MUL_SCALE : DP_DIV;
			end
			ST_LCM: begin
				ctrl.op = DP_MUL_LCM;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) ctrl.op = DP_PUBLISH;
			end
			default: begin
				ctrl.op = DP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.op == DP_PUBLISH) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/fraction_arith_unit_top.sv @@
// Multiply, divide and add/subtract with a zero denominator go from dispatch straight
// to the published result. Add and subtract first run the binary GCD steps, followed
// by the 15-step shared-divisor restoring divide and the LCM scaling.
// One item in flight; a new item is taken only after the last result is published,
// and may be taken while that result waits.
// Reset (arst_n, async, active low) clears the controller and result valid.
module fraction_arith_unit_top
	import fau_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              cmd,
	input  logic signed [NumW-1:0]  a_num,
	input  logic [DenW-1:0]         a_den,
	input  logic signed [NumW-1:0]  b_num,
	input  logic [DenW-1:0]         b_den,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [ResNW-1:0] res_num,
	output logic signed [ResDW-1:0] res_den
);

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	fau_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	fau_datapath u_dp (
		.clk     (clk),
		.ctrl    (ctrl),
		.cmd     (cmd),
		.a_num   (a_num),
		.a_den   (a_den),
		.b_num   (b_num),
		.b_den   (b_den),
		.stat    (stat),
		.res_num (res_num),
		.res_den (res_den)
	);

endmodule

@@ rtl/fau_checker.sv @@
module fau_checker
	import fau_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic [1:0]              cmd,
	input logic signed [NumW-1:0]  a_num,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [ResNW-1:0] res_num,
	input logic signed [ResDW-1:0] res_den
);

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_num) && $stable(res_den))
		else $error("stalled result changed");

	a_free_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while busy");

	a_mul_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid && cmd == CMD_MUL && a_num == '0
		|-> ##3 (out_valid && res_num == '0))
		else $error("multiply by zero numerator wrong or late");

endmodule

bind fraction_arith_unit_top fau_checker u_fau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.cmd       (cmd),
	.a_num     (a_num),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.res_num   (res_num),
	.res_den   (res_den)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import fau_pkg::*;

	typedef struct packed {
		cmd_t                   cmd;
		logic signed [NumW-1:0] a_num;
		logic [DenW-1:0]        a_den;
		logic signed [NumW-1:0] b_num;
		logic [DenW-1:0]        b_den;
	} operands_t;

	typedef struct packed {
		logic signed [ResNW-1:0] num;
		logic signed [ResDW-1:0] den;
	} fraction_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              cmd = '0;
	logic signed [NumW-1:0]  a_num = '0;
	logic [DenW-1:0]         a_den = '0;
	logic signed [NumW-1:0]  b_num = '0;
	logic [DenW-1:0]         b_den = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [ResNW-1:0] res_num;
	logic signed [ResDW-1:0] res_den;

	operands_t operand_queue[$];
	fraction_t expected_fractions[$];
	operands_t in_flight;
	int        items_taken = 0;
	int        results_seen = 0;
	int        errors = 0;
	int        op_count[4] = '{0, 0, 0, 0};
	int        hold_left = 0;
	bit        held_once = 1'b0;

	fraction_arith_unit_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.a_num    (a_num),
		.a_den    (a_den),
		.b_num    (b_num),
		.b_den    (b_den),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res_num  (res_num),
		.res_den  (res_den)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic fraction_t predict_fraction(operands_t op);
		longint    an, ad, bn, bd, x, y, t, lcm, rn, rd;
		fraction_t r;
		an = longint'($signed(op.a_num));
		bn = longint'($signed(op.b_num));
		ad = longint'(op.a_den);
		bd = longint'(op.b_den);
		rn = 0;
		rd = 0;
		case (op.cmd)
			CMD_MUL: begin
				rn = an * bn;
				rd = ad * bd;
			end
			CMD_DIV: begin
				rn = an * bd;
				rd = ad * bn;
			end
			default: begin
				if (ad != 0 && bd != 0) begin
					x = ad;
					y = bd;
					while (y != 0) begin
						t = x % y;
						x = y;
						y = t;
					end
					lcm = (ad / x) * bd;
					if (op.cmd == CMD_ADD)
						rn = (lcm / ad) * an + (lcm / bd) * bn;
					else
						rn = (lcm / ad) * an - (lcm / bd) * bn;
					rd = lcm;
				end
			end
		endcase
		r.num = rn[ResNW-1:0];
		r.den = rd[ResDW-1:0];
		return r;
	endfunction

	function automatic logic [NumW-1:0] pick_num();
		int sel;
		sel = $urandom_range(99);
		if (sel < 8)
			return 16'h8000;
		else if (sel < 16)
			return 16'h7fff;
		else if (sel < 22)
			return '0;
		else if (sel < 26)
			return '1;
		else if (sel < 45)
			return 16'($urandom_range(40) - 20);
		else
			return 16'($urandom_range(65535));
	endfunction

	function automatic logic [DenW-1:0] pick_den();
		int sel;
		sel = $urandom_range(99);
		if (sel < 2)
			return '0;
		else if (sel < 12)
			return 15'(32767 - $urandom_range(3));
		else if (sel < 30)
			return 15'($urandom_range(1, 16));
		else if (sel < 45)
			return 15'(1 << $urandom_range(14));
		else if (sel < 60)
			return 15'($urandom_range(1, 300));
		else
			return 15'($urandom_range(32767));
	endfunction

	task automatic queue_item(cmd_t c, int an, int ad, int bn, int bd);
		operands_t op;
		op.cmd   = c;
		op.a_num = 16'(an);
		op.a_den = 15'(ad);
		op.b_num = 16'(bn);
		op.b_den = 15'(bd);
		operand_queue.push_back(op);
	endtask

	task automatic queue_random_item();
		operands_t op;
		op.cmd   = cmd_t'($urandom_range(3));
		op.a_num = pick_num();
		op.b_num = pick_num();
		op.a_den = pick_den();
		op.b_den = ($urandom_range(9) == 0) ? op.a_den : pick_den();
		operand_queue.push_back(op);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		bit calm;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_fractions.push_back(predict_fraction(in_flight));
				op_count[in_flight.cmd]++;
				items_taken++;
			end
			if (!(in_valid && !in_ready)) begin
				calm = (items_taken >= 700 && items_taken < 900);
				if (operand_queue.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
					in_flight = operand_queue.pop_front();
					in_valid <= 1'b1;
					cmd      <= in_flight.cmd;
					a_num    <= in_flight.a_num;
					a_den    <= in_flight.a_den;
					b_num    <= in_flight.b_num;
					b_den    <= in_flight.b_den;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		fraction_t want;
		bit        rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_fractions.size() == 0) begin
					$error("unexpected result: res_num %0d res_den %0d", res_num, res_den);
					errors++;
				end else begin
					want = expected_fractions.pop_front();
					if (res_num !== want.num) begin
						$error("res_num: expected %0d, got %0d", $signed(want.num), res_num);
						errors++;
					end
					if (res_den !== want.den) begin
						$error("res_den: expected %0d, got %0d", $signed(want.den), res_den);
						errors++;
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (!held_once && results_seen >= 400) begin
				held_once = 1'b1;
				hold_left = 300;
				rdy = 1'b0;
			end else if (results_seen >= 700 && results_seen < 900) begin
				rdy = 1'b1;
			end else begin
				rdy = ($urandom_range(99) >= 23);
			end
			out_ready <= rdy;
		end
	end

	initial begin
		// field extremes and corner cases
		queue_item(CMD_MUL, -32768, 32767, -32768, 32767);
		queue_item(CMD_MUL, 32767, 1, -32768, 32767);
		queue_item(CMD_MUL, 0, 0, 12345, 7);
		queue_item(CMD_MUL, -1, 32767, -1, 0);
		queue_item(CMD_DIV, -32768, 32767, -32768, 32767);
		queue_item(CMD_DIV, 32767, 32767, 0, 1);
		queue_item(CMD_DIV, 5, 3, -7, 11);
		queue_item(CMD_DIV, -32768, 0, 32767, 0);
		queue_item(CMD_DIV, 1, 32767, -32768, 1);
		queue_item(CMD_ADD, 1, 1, 1, 1);
		queue_item(CMD_ADD, 32767, 32767, 32767, 32766);
		queue_item(CMD_ADD, -32768, 32767, -32768, 32766);
		queue_item(CMD_ADD, 3, 12, 5, 18);
		queue_item(CMD_ADD, 7, 16384, -9, 32767);
		queue_item(CMD_ADD, 100, 0, 5, 3);
		queue_item(CMD_ADD, 0, 0, 0, 0);
		queue_item(CMD_SUB, -32768, 32767, 32767, 32766);
		queue_item(CMD_SUB, 32767, 32766, -32768, 32767);
		queue_item(CMD_SUB, 4, 6, 4, 6);
		queue_item(CMD_SUB, 9, 8, -3, 0);
		queue_item(CMD_SUB, 1, 16384, 1, 8192);
		queue_item(CMD_SUB, -1, 21845, 1, 10922);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (operand_queue.size() != 0 || in_valid)
			@(posedge clk);
		// sender stays quiet until every result is back
		while (expected_fractions.size() != 0)
			@(posedge clk);

		repeat (1600)
			queue_random_item();
		while (operand_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_fractions.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		$display("summary: %0d items, %0d results (mul %0d, div %0d, add %0d, sub %0d)",
			items_taken, results_seen, op_count[CMD_MUL], op_count[CMD_DIV],
			op_count[CMD_ADD], op_count[CMD_SUB]);
		$display("summary: covered zero and extreme denominators and a long output stall");
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("testbench: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/fau_pkg.sv
rtl/fau_datapath.sv
rtl/fau_controller.sv
rtl/fraction_arith_unit_top.sv
rtl/fau_checker.sv
dv/testbench.sv
